// File: src/ttn_pkg.sv
// Package for the tick to nanosecond converter.
// Holds the shared widths and constants; depends on nothing.
`default_nettype none
package ttn_pkg;
    localparam int          WORD_W       = 64;
    localparam int          SHIFT_W      = 5;
    localparam int          MSB_W        = 7;
    localparam int          REM_TOP_BIT  = 33;
    localparam int          REM_W        = REM_TOP_BIT + 1;
    localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
    localparam logic [63:0] FREQ_RESET   = 64'd1000000000;
endpackage
`default_nettype wire

// File: src/ttn_div_cell.sv
// One restoring division step: one quotient bit per cell, in a chain.
// Depends on ttn_pkg.
`default_nettype none
module ttn_div_cell
    import ttn_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [WORD_W-1:0] in_rem,
    input  wire logic [WORD_W-1:0] in_qd,
    input  wire logic [WORD_W-1:0] in_div,
    input  wire logic [TAG_W-1:0]  in_tag,
    output logic                   out_valid,
    output logic [WORD_W-1:0]      out_rem,
    output logic [WORD_W-1:0]      out_qd,
    output logic [WORD_W-1:0]      out_div,
    output logic [TAG_W-1:0]       out_tag
);
    logic              valid_reg;
    logic [WORD_W-1:0] rem_reg, qd_reg, div_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [WORD_W:0]   trial, diff;
    logic              fits;
    logic [WORD_W-1:0] rem_next, qd_next;

    // The dividend shifts out of the top of qd while quotient bits enter below.
    always_comb
    begin
        trial    = {in_rem, in_qd[WORD_W-1]};
        diff     = trial - {1'b0, in_div};
        fits     = ~diff[WORD_W];
        rem_next = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        qd_next  = {in_qd[WORD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            qd_reg  <= qd_next;
            div_reg <= in_div;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_qd    = qd_reg;
    assign out_div   = div_reg;
    assign out_tag   = tag_reg;
endmodule
`default_nettype wire

// File: src/ttn_mid.sv
// Three stages between the two dividers: remainder scaling and the
// whole-second product. Depends on ttn_pkg.
`default_nettype none
module ttn_mid
    import ttn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [WORD_W-1:0] whole,
    input  wire logic [WORD_W-1:0] rem,
    input  wire logic [WORD_W-1:0] freq,
    input  wire logic              zero,
    output logic                   out_valid,
    output logic [WORD_W-1:0]      prod,
    output logic [WORD_W-1:0]      freq_shifted,
    output logic [WORD_W-1:0]      part,
    output logic                   out_zero
);
    logic [2:0]        valid_reg;
    logic [WORD_W-1:0] p_lo_reg, rem1_reg, freq1_reg;
    logic [31:0]       p_hi_reg;
    logic [SHIFT_W-1:0] sh_reg;
    logic              zero1_reg, zero2_reg, zero3_reg;
    logic [WORD_W-1:0] part2_reg, freq2_reg, part3_reg, freq3_reg, prod3_reg;
    logic [REM_W-1:0]  rs2_reg;
    logic [MSB_W-1:0]  msb;
    logic [SHIFT_W-1:0] sh_next;
    logic [WORD_W-1:0] rs_full;

    // Highest set bit of the remainder; zero gives a shift of zero anyway.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (rem[i])
            begin
                msb = MSB_W'(i);
            end
        end
        sh_next = (msb > MSB_W'(REM_TOP_BIT)) ? SHIFT_W'(msb - MSB_W'(REM_TOP_BIT)) : '0;
        rs_full = rem1_reg >> sh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg  <= WORD_W'(whole[31:0]) * NS_PER_SEC;
            p_hi_reg  <= 32'(whole[63:32] * NS_PER_SEC[31:0]);
            sh_reg    <= sh_next;
            rem1_reg  <= rem;
            freq1_reg <= freq;
            zero1_reg <= zero;

            part2_reg <= p_lo_reg + {p_hi_reg, 32'b0};
            rs2_reg   <= rs_full[REM_W-1:0];
            freq2_reg <= freq1_reg >> sh_reg;
            zero2_reg <= zero1_reg;

            prod3_reg <= WORD_W'(rs2_reg) * NS_PER_SEC;
            freq3_reg <= freq2_reg;
            part3_reg <= part2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    assign out_valid    = valid_reg[2];
    assign prod         = prod3_reg;
    assign freq_shifted = freq3_reg;
    assign part         = part3_reg;
    assign out_zero     = zero3_reg;
endmodule
`default_nettype wire

// File: src/ticks_to_nanoseconds.sv
// Top level of the tick to nanosecond converter.
// Depends on ttn_pkg, ttn_div_cell and ttn_mid.
`default_nettype none
// Converts a 64-bit tick count into nanoseconds at the configured counter
// frequency. One beat is accepted per cycle while the output is not stalled;
// each result passes through two chains of 64 division cells (one quotient
// bit each), three scaling stages and the output register. The whole pipeline
// stalls while a result waits on the output. A frequency of zero yields all ones.
module ticks_to_nanoseconds
    import ttn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [WORD_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [WORD_W-1:0] tick_count,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WORD_W-1:0]      nanoseconds
);
    localparam int TAG2_W = WORD_W + 1;

    logic [WORD_W-1:0] freq_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] ns_reg;
    logic              en;

    logic              v1 [0:WORD_W];
    logic [WORD_W-1:0] r1 [0:WORD_W];
    logic [WORD_W-1:0] q1 [0:WORD_W];
    logic [WORD_W-1:0] d1 [0:WORD_W];
    logic              t1 [0:WORD_W];

    logic              v2 [0:WORD_W];
    logic [WORD_W-1:0] r2 [0:WORD_W];
    logic [WORD_W-1:0] q2 [0:WORD_W];
    logic [WORD_W-1:0] d2 [0:WORD_W];
    logic [TAG2_W-1:0] t2 [0:WORD_W];

    logic              mid_valid, mid_zero;
    logic [WORD_W-1:0] mid_prod, mid_freq, mid_part;
    logic [WORD_W-1:0] q2_last;

    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
        end
        else if (cfg_we)
        begin
            freq_reg <= cfg_wdata;
        end
    end

    assign v1[0] = in_valid;
    assign r1[0] = '0;
    assign q1[0] = tick_count;
    assign d1[0] = freq_reg;
    assign t1[0] = (freq_reg == '0);

    for (genvar i = 0; i < WORD_W; i++)
    begin : g_div1
        ttn_div_cell #(.TAG_W(1)) u_cell
        (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v1[i]), .in_rem(r1[i]), .in_qd(q1[i]),
            .in_div(d1[i]), .in_tag(t1[i]),
            .out_valid(v1[i+1]), .out_rem(r1[i+1]), .out_qd(q1[i+1]),
            .out_div(d1[i+1]), .out_tag(t1[i+1])
        );
    end

    ttn_mid u_mid
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1[WORD_W]), .whole(q1[WORD_W]), .rem(r1[WORD_W]),
        .freq(d1[WORD_W]), .zero(t1[WORD_W]),
        .out_valid(mid_valid), .prod(mid_prod), .freq_shifted(mid_freq),
        .part(mid_part), .out_zero(mid_zero)
    );

    assign v2[0] = mid_valid;
    assign r2[0] = '0;
    assign q2[0] = mid_prod;
    assign d2[0] = mid_freq;
    assign t2[0] = {mid_zero, mid_part};

    for (genvar i = 0; i < WORD_W; i++)
    begin : g_div2
        ttn_div_cell #(.TAG_W(TAG2_W)) u_cell
        (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v2[i]), .in_rem(r2[i]), .in_qd(q2[i]),
            .in_div(d2[i]), .in_tag(t2[i]),
            .out_valid(v2[i+1]), .out_rem(r2[i+1]), .out_qd(q2[i+1]),
            .out_div(d2[i+1]), .out_tag(t2[i+1])
        );
    end

    assign q2_last = q2[WORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v2[WORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns_reg <= t2[WORD_W][WORD_W] ? '1 : (t2[WORD_W][WORD_W-1:0] + q2_last);
        end
    end

    assign out_valid   = out_valid_reg;
    assign nanoseconds = ns_reg;
endmodule
`default_nettype wire

// File: src/ttn_checker.sv
// Port-level checks for the tick to nanosecond converter, bound to the top.
// Depends on ticks_to_nanoseconds.
`default_nettype none
module ttn_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] nanoseconds
);
    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nanoseconds))
        else $error("result beat changed while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the pipeline is stalled");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input refused while the pipeline can move");
endmodule

bind ticks_to_nanoseconds ttn_checker u_ttn_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .nanoseconds(nanoseconds)
);
`default_nettype wire
